// ----- sv/ccv_pkg.sv -----
// Shared types and constants for the cyclic convolution core.
package ccv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int CONV_W   = 42;
    localparam int INDEX_W  = 10;
    localparam int LEN_W    = 4;

    localparam logic [LEN_W-1:0] LENGTH_LOG2_RESET = 4'd10;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_last;
        logic acc_clr;
    } t_dp_ctrl;

endpackage

// ----- sv/ccv_datapath.sv -----
// Sample memories and multiply-accumulate pipeline of the cyclic convolution core.
module ccv_datapath
    import ccv_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_ctrl                   i_ctrl,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic signed [SAMPLE_W-1:0] i_wr_a,
    input  logic signed [SAMPLE_W-1:0] i_wr_b,
    input  logic [AW-1:0]              i_rd_addr_a,
    input  logic [AW-1:0]              i_rd_addr_b,
    output logic                       o_finish,
    output logic signed [CONV_W-1:0]   o_conv_value,
    output logic                       o_result_valid
);

    localparam int DEPTH = 1 << AW;

    logic signed [SAMPLE_W-1:0] mem_a [DEPTH];
    logic signed [SAMPLE_W-1:0] mem_b [DEPTH];

    logic signed [SAMPLE_W-1:0] r_rd_a;
    logic signed [SAMPLE_W-1:0] r_rd_b;
    logic                       r_v1;
    logic                       r_last1;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_v2;
    logic                       r_last2;
    logic signed [CONV_W-1:0]   r_acc;
    logic signed [CONV_W-1:0]   n_acc;
    logic signed [CONV_W-1:0]   r_conv;
    logic                       r_strobe;

    // Sample memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem_a[i_wr_addr] <= i_wr_a;
        end
        r_rd_a <= mem_a[i_rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem_b[i_wr_addr] <= i_wr_b;
        end
        r_rd_b <= mem_b[i_rd_addr_b];
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_rd_a * r_rd_b);
    end

    // Running sum, wraps at 42 bits
    assign n_acc    = r_acc + CONV_W'(r_prod);
    assign o_finish = r_v2 && r_last2;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= n_acc;
        end
        if (o_finish) begin
            r_conv <= n_acc;
        end
    end

    // Pipeline valid and last flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_last1  <= 1'b0;
            r_v2     <= 1'b0;
            r_last2  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_v1     <= i_ctrl.rd_en;
            r_last1  <= i_ctrl.rd_en && i_ctrl.rd_last;
            r_v2     <= r_v1;
            r_last2  <= r_last1;
            r_strobe <= o_finish;
        end
    end

    assign o_conv_value   = r_conv;
    assign o_result_valid = r_strobe;

endmodule

// ----- sv/cyclic_convolution_core.sv -----
// Cyclic convolution core: command decode, read sequencer and configuration.
//
// Holds two sequences of signed 16-bit samples, N = 2^length_log2 entries long
// (length_log2 saturates at MAX_LENGTH_LOG2). A write command (i_command = 0)
// stores a sample pair at i_index masked to N-1 in the transfer cycle: busy
// stays low. A read command (i_command = 1) returns the exact cyclic
// convolution term c[k] = sum a[i]*b[(k-i) mod N] for k = i_index masked to
// N-1. The sum is built with one multiply-accumulate per cycle, reading one
// pair from the two sample memories each cycle. Busy stays high from the start
// transfer until the final sum is formed; the next command can be taken in the
// cycle in which o_result_valid shows the result. The result is shown on
// o_conv_value and o_out_index with that strobe, cannot be stalled and stays
// until the next read ends. Reading an unwritten entry gives an undefined term.
// Change length_log2 only while busy is low and no result is outstanding.
module cyclic_convolution_core
    import ccv_pkg::*;
#(
    parameter int MAX_LENGTH_LOG2 = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic signed [SAMPLE_W-1:0] i_sample_a,
    input  logic signed [SAMPLE_W-1:0] i_sample_b,
    input  logic                       i_cfg_we,
    input  logic [LEN_W-1:0]           i_cfg_data,
    output logic                       o_result_valid,
    output logic signed [CONV_W-1:0]   o_conv_value,
    output logic [INDEX_W-1:0]         o_out_index
);

    localparam int AW = MAX_LENGTH_LOG2;
    localparam int PW = (AW > INDEX_W) ? AW : INDEX_W;

    t_state         r_state;
    t_state         n_state;
    logic [LEN_W-1:0] r_len_log2;
    logic [AW-1:0]  act_mask;
    logic [PW-1:0]  idx_ext;
    logic [AW-1:0]  pos;
    logic [AW-1:0]  r_pos;
    logic [AW-1:0]  r_mask;
    logic [AW-1:0]  r_cnt;
    logic [AW-1:0]  n_cnt;
    logic [PW-1:0]  pos_ext;
    logic [INDEX_W-1:0] r_out_index;
    logic           accept;
    logic           finish;
    t_dp_ctrl       dp_ctrl;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_log2 <= LENGTH_LOG2_RESET;
        end else if (i_cfg_we) begin
            r_len_log2 <= i_cfg_data;
        end
    end

    // Active length mask; bits above MAX_LENGTH_LOG2 do not exist, which saturates
    always_comb begin
        for (int j = 0; j < AW; j++) begin
            act_mask[j] = (j < int'(r_len_log2));
        end
    end

    assign idx_ext = PW'(i_index);
    assign pos     = idx_ext[AW-1:0] & act_mask;
    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        dp_ctrl.wr_en   = 1'b0;
        dp_ctrl.rd_en   = 1'b0;
        dp_ctrl.rd_last = (r_cnt == r_mask);
        dp_ctrl.acc_clr = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    if (i_command == CMD_READ) begin
                        dp_ctrl.acc_clr = 1'b1;
                        n_state         = ST_RUN;
                    end else begin
                        dp_ctrl.wr_en = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                dp_ctrl.rd_en = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == r_mask) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Read position, mask and pair counter
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (accept) begin
            r_pos  <= pos;
            r_mask <= act_mask;
        end
    end

    // Result position, shown with the result strobe
    assign pos_ext = PW'(r_pos);

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_index <= pos_ext[INDEX_W-1:0];
        end
    end

    ccv_datapath #(
        .AW (AW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (dp_ctrl),
        .i_wr_addr      (pos),
        .i_wr_a         (i_sample_a),
        .i_wr_b         (i_sample_b),
        .i_rd_addr_a    (r_cnt),
        .i_rd_addr_b    ((r_pos - r_cnt) & r_mask),
        .o_finish       (finish),
        .o_conv_value   (o_conv_value),
        .o_result_valid (o_result_valid)
    );

    assign o_out_index = r_out_index;

endmodule

// ----- sv/ccv_checker.sv -----
// Port-level checks for the cyclic convolution core, bound to the top level.
module ccv_checker
    import ccv_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_result_valid
);

    // A result is only shown once the read has finished
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // One read gives one result strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // Writes complete in the transfer cycle
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_WRITE) |=> !busy)
        else $error("write left the core busy");

    // A read occupies the core and gives no immediate result
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_READ) |=> (busy && !o_result_valid))
        else $error("read did not start");

endmodule

bind cyclic_convolution_core ccv_checker u_ccv_checker (.*);

// ----- test/tb_cyclic_convolution_core.sv -----
// Self-checking testbench for the cyclic convolution core.
module tb_cyclic_convolution_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ccv_pkg::*;

    localparam int MAX_LG         = 10;
    localparam int DEPTH          = 1 << MAX_LG;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int RANDOM_ITEMS   = 580;

    typedef struct packed {
        logic signed [CONV_W-1:0] value;
        logic [INDEX_W-1:0]       pos;
    } t_term;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       start          = 1'b0;
    logic                       i_command      = CMD_WRITE;
    logic [INDEX_W-1:0]         i_index        = '0;
    logic signed [SAMPLE_W-1:0] i_sample_a     = '0;
    logic signed [SAMPLE_W-1:0] i_sample_b     = '0;
    logic                       i_cfg_we       = 1'b0;
    logic [LEN_W-1:0]           i_cfg_data     = '0;
    logic                       busy;
    logic                       o_result_valid;
    logic signed [CONV_W-1:0]   o_conv_value;
    logic [INDEX_W-1:0]         o_out_index;

    // Mirror of the sample stores and the length register
    logic signed [SAMPLE_W-1:0] samples_a [DEPTH];
    logic signed [SAMPLE_W-1:0] samples_b [DEPTH];
    logic [LEN_W-1:0]           length_q = LENGTH_LOG2_RESET;

    t_term pending_terms [$];
    int    errors;
    int    random_sent;
    int    quiet_cycles;
    bit    no_idle;

    cyclic_convolution_core #(
        .MAX_LENGTH_LOG2(MAX_LG)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_result_valid(o_result_valid),
        .o_conv_value  (o_conv_value),
        .o_out_index   (o_out_index)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Active length mask, length saturating at the maximum
    function automatic int unsigned active_mask();
        int unsigned lg;
        lg = (length_q > MAX_LG) ? MAX_LG : length_q;
        return (1 << lg) - 1;
    endfunction

    // One exact term of the cyclic convolution at position k
    function automatic logic signed [CONV_W-1:0] conv_term(input logic [INDEX_W-1:0] k);
        longint      acc;
        int unsigned mask;
        acc  = 0;
        mask = active_mask();
        for (int unsigned i = 0; i <= mask; i++)
            acc += longint'(samples_a[MAX_LG'(i)])
                 * longint'(samples_b[MAX_LG'((k - i) & mask)]);
        return acc[CONV_W-1:0];
    endfunction

    // Random sample, biased towards the extremes, zero and minus one
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Drive one command and wait for its transfer, then update the mirror or queue the expected term
    task automatic send_command(input logic cmd, input logic [INDEX_W-1:0] idx,
                                input logic signed [SAMPLE_W-1:0] a,
                                input logic signed [SAMPLE_W-1:0] b);
        logic [INDEX_W-1:0] pos;
        t_term              exp_term;
        start      <= 1'b1;
        i_command  <= cmd;
        i_index    <= idx;
        i_sample_a <= a;
        i_sample_b <= b;
        do @(posedge i_clk); while (busy);
        pos = idx & INDEX_W'(active_mask());
        if (cmd == CMD_WRITE) begin
            samples_a[pos] = a;
            samples_b[pos] = b;
        end else begin
            exp_term.value = conv_term(pos);
            exp_term.pos   = pos;
            pending_terms.insert(pending_terms.size(), exp_term);
        end
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!no_idle && $urandom_range(0, 99) < 27)
            pause_sender($urandom_range(1, 12));
    endtask

    // Hold off until every expected term has come and the core is idle
    task automatic drain();
        start <= 1'b0;
        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_length(input int unsigned lg);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= LEN_W'(lg);
        @(posedge i_clk);
        length_q = LEN_W'(lg);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_pair(input logic [INDEX_W-1:0] idx,
                              input logic signed [SAMPLE_W-1:0] a,
                              input logic signed [SAMPLE_W-1:0] b);
        maybe_idle();
        send_command(CMD_WRITE, idx, a, b);
    endtask

    task automatic read_term(input logic [INDEX_W-1:0] idx);
        maybe_idle();
        send_command(CMD_READ, idx, '0, '0);
    endtask

    // Result checker: every strobe must match the oldest expected term
    always @(posedge i_clk) begin : check_terms
        t_term want;
        if (i_rst_n && o_result_valid) begin
            if (pending_terms.size() == 0) begin
                report_mismatch($sformatf("unexpected term at index %0d", o_out_index));
            end else begin
                want = pending_terms.pop_front();
                if (o_conv_value !== want.value)
                    report_mismatch($sformatf("term %0d: value %0d, want %0d",
                                              want.pos, o_conv_value, want.value));
                if (o_out_index !== want.pos)
                    report_mismatch($sformatf("out_index %0d, want %0d",
                                              o_out_index, want.pos));
            end
        end
    end

    // Watchdog on cycles with no transfer, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("cyclic_convolution_core test failed");
            $finish;
        end
    end

    // Length one: the term is a single product, index fully masked
    task automatic test_length_one();
        set_length(0);
        write_pair(10'd1023, 16'sh8000, 16'sh8000);
        read_term(10'd0);
        read_term(10'd1023);
        write_pair(10'd0, 16'sh7fff, 16'sh8000);
        read_term(10'd512);
    endtask

    // Short lengths with wrap-around of the index arithmetic
    task automatic test_short_lengths();
        set_length(1);
        write_pair(10'd0, 16'sh7fff, 16'sh7fff);
        write_pair(10'd1, 16'shffff, 16'sh8000);
        read_term(10'd0);
        read_term(10'd3);
        set_length(2);
        write_pair(10'd4, 16'sh8000, 16'sh7fff);
        write_pair(10'd5, 16'sh0001, 16'shffff);
        write_pair(10'd6, 16'sh7fff, 16'sh8000);
        write_pair(10'd1023, 16'sh0000, 16'sh1234);
        read_term(10'd2);
        read_term(10'd1021);
    endtask

    // Full length: largest term, then a length above the maximum saturates
    task automatic test_full_length();
        set_length(MAX_LG);
        for (int i = 0; i < DEPTH; i++)
            write_pair(INDEX_W'(i), 16'sh8000, 16'sh8000);
        read_term(10'd0);
        read_term(10'd1023);
        set_length(4'd15);
        read_term(10'd512);
        write_pair(10'd5, 16'sh7fff, 16'sh7fff);
        read_term(10'd700);
    endtask

    // Random rounds, each under its own length setting
    task automatic test_random_rounds();
        int round;
        int n_items;
        int pick;
        round = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            case (round)
                0: set_length(0);
                1: set_length(MAX_LG);
                2: set_length(4'd15);
                default:
                    if (pick < 70)      set_length($urandom_range(0, 4));
                    else if (pick < 90) set_length($urandom_range(5, 8));
                    else                set_length($urandom_range(9, 15));
            endcase
            // a long stretch with no random idling
            no_idle = (round == 3 || round == 4);
            n_items = $urandom_range(30, 42);
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                if ($urandom_range(0, 99) < 40)
                    read_term(INDEX_W'($urandom));
                else
                    write_pair(INDEX_W'($urandom), random_sample(), random_sample());
                random_sent++;
            end
            round++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors      = 0;
        random_sent = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            samples_a[MAX_LG'(i)] = '0;
            samples_b[MAX_LG'(i)] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_length_one();
        test_short_lengths();
        test_full_length();
        test_random_rounds();

        drain();
        repeat (active_mask() + 8) @(posedge i_clk);
        if (pending_terms.size() != 0)
            report_mismatch($sformatf("%0d expected terms never came", pending_terms.size()));
        if (errors == 0)
            $display("cyclic_convolution_core test passed");
        else
            $display("cyclic_convolution_core test failed");
        $finish;
    end

endmodule
